// ===== rtl/core/gdd_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date difference core.
// No dependencies; imported by the interfaces and every module of the core.
package gdd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 22;

   // Day numbers from 1 Jan of year 0; 16383 years * 366 stays below 2^23.
   localparam int DN_W    = 23;

   // Reciprocal multiply for x / 100, exact for x below 2^15.
   localparam int OPND_W      = 15;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = OPND_W + RECIP_W;
   localparam int RECIP_SHIFT = 19;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam int MONTHS = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Quotients the sequencer gathers per date.
   typedef enum logic [1:0] {
      OP_CENT_UP = 2'd0,   // (y + 99) / 100
      OP_QUAD_UP = 2'd1,   // (y + 399) / 400
      OP_CENT    = 2'd2,   // y / 100, for the century test
      OP_QUAD    = 2'd3    // (y / 4) / 100, for the 400-year test
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_QUO,
      ST_DAYNUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      logic   mul;
      logic   quo;
      logic   daynum;
      logic   finish;
      op_type op;
      logic   side;     // 0: start date, 1: end date
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/gdd_if.sv =====
// Valid/ready channel interfaces for the date difference core.
// Depends on gdd_pkg for field widths.
interface gdd_req_if import gdd_pkg::*;;
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  start_year;
   logic [MONTH_W-1:0] start_month;
   logic [DAY_W-1:0]   start_day;
   logic [YEAR_W-1:0]  end_year;
   logic [MONTH_W-1:0] end_month;
   logic [DAY_W-1:0]   end_day;
   logic               include_end;

   modport source(output valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, include_end, input ready);
   modport sink(input valid, start_year, start_month, start_day,
                end_year, end_month, end_day, include_end, output ready);
endinterface

interface gdd_rsp_if import gdd_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] day_count;
   logic               invalid_date;

   modport source(output valid, day_count, invalid_date, input ready);
   modport sink(input valid, day_count, invalid_date, output ready);
endinterface

// ===== rtl/core/gregorian_date_difference_core.sv =====
// Gregorian date difference core: days from start date to end date.
// Sequence: two dates x four multiply/capture pairs on the shared reciprocal
//   multiplier + one day-number step each, then one result step.
// One request at a time: the sequencer takes the next request only after
//   the result step, which waits while the response register is held.
// Reset: synchronous, active high; clears sequencer state and response valid.
module gregorian_date_difference_core import gdd_pkg::*; (
   input logic        clock,
   input logic        reset,
   gdd_req_if.sink    req_bus,
   gdd_rsp_if.source  rsp_bus
);

   // Controller and datapath talk only through these two groups.
   cmd_type    cmd;
   status_type status;

   // The controller accepts a request only in idle; the datapath keeps its
   // own response register, so a finished result can wait for rsp ready
   // while the sequencer returns to idle and takes the next request.
   gdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: per date, four quotients by 100 via a registered reciprocal
   // multiply (century terms of the day number and the leap test), then the
   // day number and date check; finally the clipped difference.
   gdd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_start_year   (req_bus.start_year),
      .req_start_month  (req_bus.start_month),
      .req_start_day    (req_bus.start_day),
      .req_end_year     (req_bus.end_year),
      .req_end_month    (req_bus.end_month),
      .req_end_day      (req_bus.end_day),
      .req_include_end  (req_bus.include_end),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_day_count    (rsp_bus.day_count),
      .rsp_invalid_date (rsp_bus.invalid_date)
   );

endmodule

// ===== rtl/core/gdd_ctrl.sv =====
// Sequencer for the date difference core: steps quotients, day numbers, result.
// Depends on gdd_pkg; drives the datapath through cmd_type.
module gdd_ctrl import gdd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      side_ff, side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_CENT_UP;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      side_in  = side_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
               op_in    = OP_CENT_UP;
               side_in  = 1'b0;
            end
         end
         ST_MUL: state_in = ST_QUO;
         ST_QUO: begin
            if (op_ff == OP_QUAD) begin
               state_in = ST_DAYNUM;
            end else begin
               state_in = ST_MUL;
               op_in    = op_type'(op_ff + 2'd1);
            end
         end
         ST_DAYNUM: begin
            if (side_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
               op_in    = OP_CENT_UP;
               side_in  = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.mul    = (state_ff == ST_MUL);
      cmd.quo    = (state_ff == ST_QUO);
      cmd.daynum = (state_ff == ST_DAYNUM);
      cmd.finish = (state_ff == ST_FINISH) && status.out_free;
      cmd.op     = op_ff;
      cmd.side   = side_ff;
   end

endmodule

// ===== rtl/core/gdd_datapath.sv =====
// Datapath: item registers, shared reciprocal multiplier, day number and result logic.
// Depends on gdd_pkg; commanded by gdd_ctrl.
module gdd_datapath import gdd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [YEAR_W-1:0]  req_end_year,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic               req_include_end,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [COUNT_W-1:0] rsp_day_count,
   output logic               rsp_invalid_date
);

   logic [YEAR_W-1:0]  sy_ff, ey_ff;
   logic [MONTH_W-1:0] sm_ff, em_ff;
   logic [DAY_W-1:0]   sd_ff, ed_ff;
   logic               inc_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QUOT_W-1:0]  quot_ff [4];
   logic [DN_W-1:0]    dn_ff [2];
   logic               ok_ff [2];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               invalid_ff, invalid_in;
   logic               rsp_valid_ff;

   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;
   logic [OPND_W-1:0]  operand, year_400;
   logic               cent_hit, quad_hit, leap, date_ok;
   logic [DN_W-1:0]    dn_in;
   logic [DN_W-1:0]    diff;
   logic [DN_W:0]      total;

   assign year  = cmd.side ? ey_ff : sy_ff;
   assign month = cmd.side ? em_ff : sm_ff;
   assign day   = cmd.side ? ed_ff : sd_ff;

   // quotient operand selection
   assign year_400 = {1'b0, year} + 15'd399;
   always_comb begin
      unique case (cmd.op)
         OP_CENT_UP: operand = {1'b0, year} + 15'd99;
         OP_QUAD_UP: operand = {2'b00, year_400[OPND_W-1:2]};
         OP_CENT:    operand = {1'b0, year};
         OP_QUAD:    operand = {3'b000, year[YEAR_W-1:2]};
         default:    operand = '0;
      endcase
   end

   assign prod_in = PROD_W'(operand) * PROD_W'(RECIP_100);

   // leap test from the gathered quotients
   assign cent_hit = (16'(quot_ff[OP_CENT]) * 16'd100) == 16'(year);
   assign quad_hit = (18'(quot_ff[OP_QUAD]) * 18'd400) == 18'(year);
   assign leap     = quad_hit || ((year[1:0] == 2'b00) && !cent_hit);

   assign date_ok = (month >= 4'd1) && (month <= 4'(MONTHS)) && (day != '0)
                    && (day <= month_len(month, leap));

   assign dn_in = DN_W'(year) * DN_W'(365)
                + DN_W'(({1'b0, year} + 15'd3) >> 2)
                - DN_W'(quot_ff[OP_CENT_UP])
                + DN_W'(quot_ff[OP_QUAD_UP])
                + DN_W'(days_before(month))
                + DN_W'((month > 4'd2) && leap)
                + DN_W'(day)
                - DN_W'(1);

   // final count, clipped at zero and saturated at COUNT_MAX
   assign diff  = (dn_ff[0] < dn_ff[1]) ? (dn_ff[1] - dn_ff[0]) : '0;
   assign total = {1'b0, diff} + (DN_W+1)'(inc_ff);

   always_comb begin
      invalid_in = !(ok_ff[0] && ok_ff[1]);
      if (invalid_in) begin
         count_in = '0;
      end else if (total > (DN_W+1)'(COUNT_MAX)) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = total[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sy_ff  <= req_start_year;
         sm_ff  <= req_start_month;
         sd_ff  <= req_start_day;
         ey_ff  <= req_end_year;
         em_ff  <= req_end_month;
         ed_ff  <= req_end_day;
         inc_ff <= req_include_end;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.quo) begin
         quot_ff[cmd.op] <= prod_ff[RECIP_SHIFT +: QUOT_W];
      end
      if (cmd.daynum) begin
         dn_ff[cmd.side] <= dn_in;
         ok_ff[cmd.side] <= date_ok;
      end
      if (cmd.finish) begin
         count_ff   <= count_in;
         invalid_ff <= invalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_day_count    = count_ff;
   assign rsp_invalid_date = invalid_ff;

endmodule
